/* hw/rtl/kf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package kf_pkg;

   // default number format
   localparam int DEF_WORD_BITS = 32;
   localparam int DEF_FRAC_BITS = 16;

   // word memory: store words first, then scratch for intermediate matrices
   localparam int ADDR_BITS   = 7;
   localparam int MEM_DEPTH   = 128;
   localparam int STORE_DEPTH = 40;

   // store words
   localparam logic [ADDR_BITS-1:0] A_F = 7'd0;
   localparam logic [ADDR_BITS-1:0] A_H = 7'd9;
   localparam logic [ADDR_BITS-1:0] A_Q = 7'd15;
   localparam logic [ADDR_BITS-1:0] A_R = 7'd24;
   localparam logic [ADDR_BITS-1:0] A_X = 7'd28;
   localparam logic [ADDR_BITS-1:0] A_P = 7'd31;

   // scratch words
   localparam logic [ADDR_BITS-1:0] A_XP   = 7'd40;   // predicted state
   localparam logic [ADDR_BITS-1:0] A_FP   = 7'd43;   // F*P, later P*(I-KH)^T
   localparam logic [ADDR_BITS-1:0] A_PP   = 7'd52;   // predicted covariance
   localparam logic [ADDR_BITS-1:0] A_PHT  = 7'd61;
   localparam logic [ADDR_BITS-1:0] A_S    = 7'd67;   // innovation matrix
   localparam logic [ADDR_BITS-1:0] A_S3   = 7'd70;
   localparam logic [ADDR_BITS-1:0] A_DET  = 7'd71;
   localparam logic [ADDR_BITS-1:0] A_SI   = 7'd72;   // inverse of S
   localparam logic [ADDR_BITS-1:0] A_K    = 7'd76;
   localparam logic [ADDR_BITS-1:0] A_Z    = 7'd82;
   localparam logic [ADDR_BITS-1:0] A_HX   = 7'd84;
   localparam logic [ADDR_BITS-1:0] A_Y    = 7'd86;
   localparam logic [ADDR_BITS-1:0] A_KY   = 7'd88;
   localparam logic [ADDR_BITS-1:0] A_RKT  = 7'd91;
   localparam logic [ADDR_BITS-1:0] A_KRKT = 7'd97;
   localparam logic [ADDR_BITS-1:0] A_KH   = 7'd106;  // K*H, then I-K*H in place
   localparam logic [ADDR_BITS-1:0] A_B    = 7'd115;

   // element operation kinds
   localparam logic [2:0] K_MUL  = 3'd0;   // sum of rounded products
   localparam logic [2:0] K_MSUB = 3'd1;   // first product minus second
   localparam logic [2:0] K_ADD  = 3'd2;
   localparam logic [2:0] K_SUB  = 3'd3;
   localparam logic [2:0] K_MOV  = 3'd4;
   localparam logic [2:0] K_IDM  = 3'd5;   // identity minus b

   // sequence points
   localparam logic [4:0] OP_FIRST = 5'd0;
   localparam logic [4:0] OP_DET   = 5'd7;
   localparam logic [4:0] OP_GAIN  = 5'd8;
   localparam logic [4:0] OP_LAST  = 5'd19;
   localparam logic [4:0] OP_CPX   = 5'd20;
   localparam logic [4:0] OP_CPP   = 5'd21;

   // result status and request types
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_SING  = 2'd1;
   localparam logic [1:0] ST_WRITE = 2'd2;
   localparam logic       REQ_WRITE = 1'b1;

   // one matrix operation: c[i][j] = sum_k a(i,k,j) op b(i,k,j)
   typedef struct packed {
      logic [2:0]           kind;
      logic [3:0]           n;
      logic [1:0]           m;
      logic [1:0]           p;
      logic [ADDR_BITS-1:0] a_base;
      logic signed [3:0]    a_si;
      logic signed [3:0]    a_sk;
      logic signed [3:0]    a_sj;
      logic [ADDR_BITS-1:0] b_base;
      logic signed [3:0]    b_si;
      logic signed [3:0]    b_sk;
      logic signed [3:0]    b_sj;
      logic [ADDR_BITS-1:0] c_base;
   } op_type;

   function automatic op_type mk(input logic [2:0] kind, input int n, input int m,
                                 input int p, input logic [ADDR_BITS-1:0] ab,
                                 input int ai, input int ak, input int aj,
                                 input logic [ADDR_BITS-1:0] bb,
                                 input int bi, input int bk, input int bj,
                                 input logic [ADDR_BITS-1:0] cb);
      op_type o;
      o.kind   = kind;
      o.n      = 4'(n);
      o.m      = 2'(m);
      o.p      = 2'(p);
      o.a_base = ab;
      o.a_si   = 4'(ai);
      o.a_sk   = 4'(ak);
      o.a_sj   = 4'(aj);
      o.b_base = bb;
      o.b_si   = 4'(bi);
      o.b_sk   = 4'(bk);
      o.b_sj   = 4'(bj);
      o.c_base = cb;
      return o;
   endfunction

   // operation program of one measurement step
   function automatic op_type op_entry(input logic [4:0] idx);
      op_type o;
      case (idx)
         5'd0:  o = mk(K_MUL,  3, 3, 1, A_F,    3, 1, 0, A_X,    0, 1, 0, A_XP);
         5'd1:  o = mk(K_MUL,  3, 3, 3, A_F,    3, 1, 0, A_P,    0, 3, 1, A_FP);
         5'd2:  o = mk(K_MUL,  3, 3, 3, A_FP,   3, 1, 0, A_F,    0, 1, 3, A_PP);
         5'd3:  o = mk(K_ADD,  9, 1, 1, A_PP,   1, 0, 0, A_Q,    1, 0, 0, A_PP);
         5'd4:  o = mk(K_MUL,  3, 3, 2, A_PP,   3, 1, 0, A_H,    0, 1, 3, A_PHT);
         5'd5:  o = mk(K_MUL,  2, 3, 2, A_H,    3, 1, 0, A_PHT,  0, 2, 1, A_S);
         5'd6:  o = mk(K_ADD,  4, 1, 1, A_S,    1, 0, 0, A_R,    1, 0, 0, A_S);
         5'd7:  o = mk(K_MSUB, 1, 2, 1, A_S,    0, 1, 0, A_S3,   0, -1, 0, A_DET);
         5'd8:  o = mk(K_MUL,  3, 2, 2, A_PHT,  2, 1, 0, A_SI,   0, 2, 1, A_K);
         5'd9:  o = mk(K_MUL,  2, 3, 1, A_H,    3, 1, 0, A_XP,   0, 1, 0, A_HX);
         5'd10: o = mk(K_SUB,  2, 1, 1, A_Z,    1, 0, 0, A_HX,   1, 0, 0, A_Y);
         5'd11: o = mk(K_MUL,  3, 2, 1, A_K,    2, 1, 0, A_Y,    0, 1, 0, A_KY);
         5'd12: o = mk(K_ADD,  3, 1, 1, A_KY,   1, 0, 0, A_XP,   1, 0, 0, A_X);
         5'd13: o = mk(K_MUL,  2, 2, 3, A_R,    2, 1, 0, A_K,    0, 1, 2, A_RKT);
         5'd14: o = mk(K_MUL,  3, 2, 3, A_K,    2, 1, 0, A_RKT,  0, 3, 1, A_KRKT);
         5'd15: o = mk(K_MUL,  3, 2, 3, A_K,    2, 1, 0, A_H,    0, 3, 1, A_KH);
         5'd16: o = mk(K_IDM,  3, 1, 3, A_KH,   0, 0, 0, A_KH,   3, 0, 1, A_KH);
         5'd17: o = mk(K_MUL,  3, 3, 3, A_PP,   3, 1, 0, A_KH,   0, 1, 3, A_FP);
         5'd18: o = mk(K_MUL,  3, 3, 3, A_KH,   3, 1, 0, A_FP,   0, 3, 1, A_B);
         5'd19: o = mk(K_ADD,  9, 1, 1, A_B,    1, 0, 0, A_KRKT, 1, 0, 0, A_P);
         5'd20: o = mk(K_MOV,  3, 1, 1, A_XP,   1, 0, 0, A_XP,   1, 0, 0, A_X);
         5'd21: o = mk(K_MOV,  9, 1, 1, A_PP,   1, 0, 0, A_PP,   1, 0, 0, A_P);
         default: o = mk(K_MOV, 1, 1, 1, A_XP,  0, 0, 0, A_XP,   0, 0, 0, A_XP);
      endcase
      return o;
   endfunction

   // element address from base, counters and strides
   function automatic logic [ADDR_BITS-1:0] elem_addr(input logic [ADDR_BITS-1:0] base,
                                                      input logic [3:0] i,
                                                      input logic [1:0] k,
                                                      input logic [1:0] j,
                                                      input logic signed [3:0] si,
                                                      input logic signed [3:0] sk,
                                                      input logic signed [3:0] sj);
      logic signed [9:0] s;
      s = 10'(signed'({3'b000, base}))
        + 10'(signed'({1'b0, i})) * 10'(si)
        + 10'(signed'({1'b0, k})) * 10'(sk)
        + 10'(signed'({1'b0, j})) * 10'(sj);
      return s[ADDR_BITS-1:0];
   endfunction

   // numerators of the 2x2 inverse: S3, -S1, -S2, S0
   function automatic logic [ADDR_BITS-1:0] div_src(input logic [1:0] d);
      logic [ADDR_BITS-1:0] a;
      case (d)
         2'd0:    a = A_S + 7'd3;
         2'd1:    a = A_S + 7'd1;
         2'd2:    a = A_S + 7'd2;
         default: a = A_S;
      endcase
      return a;
   endfunction

   function automatic logic div_neg(input logic [1:0] d);
      return (d == 2'd1) || (d == 2'd2);
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/kalman_filter_3state_2meas_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel  | ports                                   | direction
// req      | req_valid/req_ready, req_type,          | in
//          | req_word_index, req_word_value,         |
//          | req_meas_0, req_meas_1                  |
// rsp      | rsp_valid/rsp_ready, rsp_est_0..2,      | out
//          | rsp_status                              |
//
// A write beat goes from idle through S_FIN to the rsp register. A measurement
// beat runs the operation program over one multiply-accumulate unit fed by a
// two-read-port word memory (one product per cycle, with a drain between
// operations) plus a 1-bit-per-cycle divider for the 2x2 inverse.
// After reset the 40 store words are cleared before req_ready.
// A finished result waits in the rsp register while the next beat is taken.

module kalman_filter_3state_2meas_core #(
   parameter int WORD_BITS = kf_pkg::DEF_WORD_BITS,
   parameter int FRAC_BITS = kf_pkg::DEF_FRAC_BITS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_type,
   input  wire logic [5:0]          req_word_index,
   input  wire logic signed [31:0]  req_word_value,
   input  wire logic signed [31:0]  req_meas_0,
   input  wire logic signed [31:0]  req_meas_1,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic signed [31:0]       rsp_est_0,
   output logic signed [31:0]       rsp_est_1,
   output logic signed [31:0]       rsp_est_2,
   output logic [1:0]               rsp_status
);
   import kf_pkg::*;

   localparam int W   = WORD_BITS;
   localparam int F   = FRAC_BITS;
   localparam int AW  = 2 * W + 2;
   localparam int DVB = W + F;
   localparam int DCW = $clog2(DVB + 1);

   localparam logic signed [AW-1:0]  SAT_HI = {{(AW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [AW-1:0]  SAT_LO = ~SAT_HI;
   localparam logic signed [DVB:0]   Q_HI   = {{(DVB-W+2){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [DVB:0]   Q_LO   = ~Q_HI;
   localparam logic signed [32:0]    IN_HI  = {{(34-W){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [32:0]    IN_LO  = ~IN_HI;
   localparam logic signed [AW-1:0]  ONE    = AW'(1) << F;
   localparam logic signed [AW-1:0]  HALF   = AW'(1) << (F - 1);

   localparam logic [3:0] S_CLR   = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_ZW    = 4'd2;
   localparam logic [3:0] S_RUN   = 4'd3;
   localparam logic [3:0] S_DRAIN = 4'd4;
   localparam logic [3:0] S_DRD   = 4'd5;
   localparam logic [3:0] S_DLD   = 4'd6;
   localparam logic [3:0] S_DIT   = 4'd7;
   localparam logic [3:0] S_DWR   = 4'd8;
   localparam logic [3:0] S_FIN   = 4'd9;

   function automatic logic signed [W-1:0] sat_acc(input logic signed [AW-1:0] v);
      if (v > SAT_HI) return SAT_HI[W-1:0];
      if (v < SAT_LO) return SAT_LO[W-1:0];
      return v[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] sat_q(input logic signed [DVB:0] v);
      if (v > Q_HI) return Q_HI[W-1:0];
      if (v < Q_LO) return Q_LO[W-1:0];
      return v[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] sat_in(input logic signed [31:0] v);
      logic signed [32:0] x;
      x = 33'(v);
      if (x > IN_HI) return IN_HI[W-1:0];
      if (x < IN_LO) return IN_LO[W-1:0];
      return x[W-1:0];
   endfunction

   // word memory
   logic [W-1:0]           mem [MEM_DEPTH];
   logic [W-1:0]           rd_a_ff, rd_b_ff;
   logic [ADDR_BITS-1:0]   rd_a_addr, rd_b_addr;
   logic                   wr_en;
   logic [ADDR_BITS-1:0]   wr_addr;
   logic [W-1:0]           wr_data;

   // control
   logic [3:0]             state_ff, state_in;
   logic [4:0]             op_ff, op_in;
   logic [3:0]             i_ff, i_in;
   logic [1:0]             j_ff, j_in, k_ff, k_in;
   logic [1:0]             drain_ff, drain_in;
   logic [5:0]             clr_ff, clr_in;
   logic [1:0]             dsel_ff, dsel_in;
   logic [DCW-1:0]         dcnt_ff, dcnt_in;
   logic [1:0]             status_ff, status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   op_type                 cur;
   logic                   elem_last, op_last;

   // datapath registers
   logic signed [W-1:0]    det_ff, det_in;
   logic signed [W-1:0]    z1_ff, z1_in;
   logic [W-1:0]           rem_ff, rem_in;
   logic [DVB-1:0]         dvd_ff, dvd_in, quo_ff, quo_in;
   logic [W-1:0]           dsr_ff, dsr_in;
   logic                   qneg_ff, qneg_in;
   logic signed [W-1:0]    x_ff [3];
   logic signed [W-1:0]    x_in [3];
   logic signed [31:0]     est_ff [3];
   logic signed [31:0]     est_in [3];
   logic [1:0]             rsp_status_ff, rsp_status_in;

   // pipeline tags
   logic                   s1_valid_ff, s1_valid_in, s2_valid_ff, s2_valid_in;
   logic [2:0]             s1_kind_ff, s1_kind_in, s2_kind_ff, s2_kind_in;
   logic                   s1_first_ff, s1_first_in, s2_first_ff, s2_first_in;
   logic                   s1_last_ff, s1_last_in, s2_last_ff, s2_last_in;
   logic                   s1_neg_ff, s1_neg_in, s2_neg_ff, s2_neg_in;
   logic                   s1_diag_ff, s1_diag_in;
   logic [ADDR_BITS-1:0]   s1_c_ff, s1_c_in, s2_c_ff, s2_c_in;
   logic signed [AW-1:0]   p2_ff, p2_in, acc_ff, acc_in;

   // datapath comb
   logic signed [W-1:0]    a_s, b_s;
   logic signed [2*W-1:0]  mul_w;
   logic signed [AW-1:0]   rnd, term, sum;
   logic signed [W-1:0]    elem_val;
   logic signed [W:0]      numx, magx;
   logic [W:0]             sh;
   logic                   qbit;
   logic signed [DVB:0]    qs;
   logic [1:0]             xi;

   assign cur       = op_entry(op_ff);
   assign elem_last = (k_ff == cur.m - 2'd1);
   assign op_last   = elem_last && (j_ff == cur.p - 2'd1) && (i_ff == cur.n - 4'd1);
   assign a_s       = signed'(rd_a_ff);
   assign b_s       = signed'(rd_b_ff);
   assign mul_w     = a_s * b_s;

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_est_0  = est_ff[0];
   assign rsp_est_1  = est_ff[1];
   assign rsp_est_2  = est_ff[2];
   assign rsp_status = rsp_status_ff;

   // read addresses
   always_comb begin
      if (state_ff == S_DRD) begin
         rd_a_addr = div_src(dsel_ff);
      end else begin
         rd_a_addr = elem_addr(cur.a_base, i_ff, k_ff, j_ff, cur.a_si, cur.a_sk, cur.a_sj);
      end
      rd_b_addr = elem_addr(cur.b_base, i_ff, k_ff, j_ff, cur.b_si, cur.b_sk, cur.b_sj);
   end

   // stage 2: round, accumulate, saturate
   always_comb begin
      rnd = (p2_ff + HALF) >>> F;
      if (s2_kind_ff == K_MUL || s2_kind_ff == K_MSUB) begin
         term = s2_neg_ff ? -rnd : rnd;
      end else begin
         term = p2_ff;
      end
      sum      = s2_first_ff ? term : acc_ff + term;
      elem_val = sat_acc(sum);
      qs       = qneg_ff ? -signed'({1'b0, quo_ff}) : signed'({1'b0, quo_ff});
   end

   // memory write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = A_Z;
      wr_data = '0;
      if (state_ff == S_CLR) begin
         wr_en   = 1'b1;
         wr_addr = ADDR_BITS'(clr_ff);
      end else if (state_ff == S_IDLE && req_valid) begin
         if (req_type == REQ_WRITE) begin
            wr_en   = (req_word_index < 6'(STORE_DEPTH));
            wr_addr = ADDR_BITS'(req_word_index);
            wr_data = sat_in(req_word_value);
         end else begin
            wr_en   = 1'b1;
            wr_addr = A_Z;
            wr_data = sat_in(req_meas_0);
         end
      end else if (state_ff == S_ZW) begin
         wr_en   = 1'b1;
         wr_addr = A_Z + 7'd1;
         wr_data = z1_ff;
      end else if (state_ff == S_DWR) begin
         wr_en   = 1'b1;
         wr_addr = A_SI + ADDR_BITS'(dsel_ff);
         wr_data = sat_q(qs);
      end else if (s2_valid_ff && s2_last_ff) begin
         wr_en   = 1'b1;
         wr_addr = s2_c_ff;
         wr_data = elem_val;
      end
   end

   // next state and datapath
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      drain_in      = drain_ff;
      clr_in        = clr_ff;
      dsel_in       = dsel_ff;
      dcnt_in       = dcnt_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      est_in        = est_ff;
      det_in        = det_ff;
      z1_in         = z1_ff;
      rem_in        = rem_ff;
      dvd_in        = dvd_ff;
      quo_in        = quo_ff;
      dsr_in        = dsr_ff;
      qneg_in       = qneg_ff;
      x_in          = x_ff;
      numx          = '0;
      magx          = '0;
      sh            = '0;
      qbit          = 1'b0;
      xi            = '0;

      // stage 0 tags
      s1_valid_in = 1'b0;
      s1_kind_in  = cur.kind;
      s1_first_in = (k_ff == 2'd0);
      s1_last_in  = elem_last;
      s1_neg_in   = (cur.kind == K_MSUB) && (k_ff == 2'd1);
      s1_diag_in  = (i_ff == {2'b00, j_ff});
      s1_c_in     = cur.c_base + 7'({3'b000, i_ff} * {5'b00000, cur.p}) + 7'(j_ff);

      // stage 1: product or element operation
      s2_valid_in = s1_valid_ff;
      s2_kind_in  = s1_kind_ff;
      s2_first_in = s1_first_ff;
      s2_last_in  = s1_last_ff;
      s2_neg_in   = s1_neg_ff;
      s2_c_in     = s1_c_ff;
      case (s1_kind_ff)
         K_MUL, K_MSUB: p2_in = AW'(mul_w);
         K_ADD:         p2_in = AW'(a_s) + AW'(b_s);
         K_SUB:         p2_in = AW'(a_s) - AW'(b_s);
         K_IDM:         p2_in = (s1_diag_ff ? ONE : AW'(0)) - AW'(b_s);
         default:       p2_in = AW'(a_s);
      endcase
      acc_in = s2_valid_ff ? sum : acc_ff;

      // determinant capture
      if (s2_valid_ff && s2_last_ff && s2_c_ff == A_DET) begin
         det_in = elem_val;
      end

      // state shadow follows every write of the store state words
      if (wr_en && wr_addr >= A_X && wr_addr < A_X + 7'd3) begin
         xi        = 2'(wr_addr - A_X);
         x_in[xi]  = signed'(wr_data);
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLR: begin
            clr_in = clr_ff + 6'd1;
            if (clr_ff == 6'(STORE_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               if (req_type == REQ_WRITE) begin
                  status_in = ST_WRITE;
                  state_in  = S_FIN;
               end else begin
                  z1_in    = sat_in(req_meas_1);
                  state_in = S_ZW;
               end
            end
         end
         S_ZW: begin
            op_in    = OP_FIRST;
            i_in     = '0;
            j_in     = '0;
            k_in     = '0;
            state_in = S_RUN;
         end
         S_RUN: begin
            s1_valid_in = 1'b1;
            if (elem_last) begin
               k_in = '0;
               if (j_ff == cur.p - 2'd1) begin
                  j_in = '0;
                  i_in = i_ff + 4'd1;
               end else begin
                  j_in = j_ff + 2'd1;
               end
            end else begin
               k_in = k_ff + 2'd1;
            end
            if (op_last) begin
               drain_in = '0;
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            drain_in = drain_ff + 2'd1;
            if (drain_ff == 2'd2) begin
               i_in = '0;
               j_in = '0;
               k_in = '0;
               if (op_ff == OP_DET) begin
                  if (det_ff == '0) begin
                     op_in    = OP_CPX;
                     state_in = S_RUN;
                  end else begin
                     dsel_in  = '0;
                     state_in = S_DRD;
                  end
               end else if (op_ff == OP_LAST) begin
                  status_in = ST_DONE;
                  state_in  = S_FIN;
               end else if (op_ff == OP_CPP) begin
                  status_in = ST_SING;
                  state_in  = S_FIN;
               end else begin
                  op_in    = op_ff + 5'd1;
                  state_in = S_RUN;
               end
            end
         end
         S_DRD: begin
            state_in = S_DLD;
         end
         S_DLD: begin
            // magnitudes and quotient sign
            numx    = {a_s[W-1], a_s};
            if (div_neg(dsel_ff)) begin
               numx = -numx;
            end
            magx    = numx[W] ? -numx : numx;
            qneg_in = numx[W] ^ det_ff[W-1];
            dvd_in  = {magx[W-1:0], {F{1'b0}}};
            dsr_in  = det_ff[W-1] ? W'(-det_ff) : W'(det_ff);
            rem_in  = '0;
            quo_in  = '0;
            dcnt_in = '0;
            state_in = S_DIT;
         end
         S_DIT: begin
            // one restoring step per cycle
            sh = {rem_ff, dvd_ff[DVB-1]};
            if (sh >= {1'b0, dsr_ff}) begin
               rem_in = W'(sh - {1'b0, dsr_ff});
               qbit   = 1'b1;
            end else begin
               rem_in = sh[W-1:0];
            end
            dvd_in  = dvd_ff << 1;
            quo_in  = {quo_ff[DVB-2:0], qbit};
            dcnt_in = dcnt_ff + DCW'(1);
            if (dcnt_ff == DCW'(DVB - 1)) begin
               state_in = S_DWR;
            end
         end
         S_DWR: begin
            dsel_in = dsel_ff + 2'd1;
            if (dsel_ff == 2'd3) begin
               op_in    = OP_GAIN;
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               state_in = S_RUN;
            end else begin
               state_in = S_DRD;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               est_in[0]     = 32'(x_ff[0]);
               est_in[1]     = 32'(x_ff[1]);
               est_in[2]     = 32'(x_ff[2]);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // memory with registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         op_ff        <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         drain_ff     <= '0;
         clr_ff       <= '0;
         dsel_ff      <= '0;
         dcnt_ff      <= '0;
         status_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         x_ff[0]      <= '0;
         x_ff[1]      <= '0;
         x_ff[2]      <= '0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         drain_ff     <= drain_in;
         clr_ff       <= clr_in;
         dsel_ff      <= dsel_in;
         dcnt_ff      <= dcnt_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         x_ff         <= x_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_kind_ff    <= s1_kind_in;
      s1_first_ff   <= s1_first_in;
      s1_last_ff    <= s1_last_in;
      s1_neg_ff     <= s1_neg_in;
      s1_diag_ff    <= s1_diag_in;
      s1_c_ff       <= s1_c_in;
      s2_kind_ff    <= s2_kind_in;
      s2_first_ff   <= s2_first_in;
      s2_last_ff    <= s2_last_in;
      s2_neg_ff     <= s2_neg_in;
      s2_c_ff       <= s2_c_in;
      p2_ff         <= p2_in;
      acc_ff        <= acc_in;
      det_ff        <= det_in;
      z1_ff         <= z1_in;
      rem_ff        <= rem_in;
      dvd_ff        <= dvd_in;
      quo_ff        <= quo_in;
      dsr_ff        <= dsr_in;
      qneg_ff       <= qneg_in;
      est_ff        <= est_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

`default_nettype wire

/* bench/kalman_filter_3state_2meas_core_tb.sv */
`timescale 1ns / 1ps

module kalman_filter_3state_2meas_core_tb;
   import kf_pkg::*;

   localparam int MAX_CYCLES = 4_000_000;
   localparam int ONE = 1 << DEF_FRAC_BITS;

   // one expected result beat
   typedef struct {
      logic signed [31:0] est[3];
      logic [1:0]         status;
   } estimate_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_type = 1'b0;
   logic [5:0] req_word_index = '0;
   logic signed [31:0] req_word_value = '0;
   logic signed [31:0] req_meas_0 = '0;
   logic signed [31:0] req_meas_1 = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_est_0, rsp_est_1, rsp_est_2;
   logic [1:0] rsp_status;

   kalman_filter_3state_2meas_core uut (.*);

   always #5 clock = ~clock;

   // filter state mirror and pending estimates
   longint filter_store[STORE_DEPTH];
   estimate_type pending_estimates[$];
   int error_count = 0;
   int cycle_count = 0;
   bit idle_enable = 1'b1;

   function automatic longint clamp_word(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // rounded fixed-point product, half toward plus infinity
   function automatic longint fx_mul(longint a, longint b);
      return (a * b + (64'sd1 <<< (DEF_FRAC_BITS - 1))) >>> DEF_FRAC_BITS;
   endfunction

   // c(n x p) = a(n x m) * b(m x p), row-major
   function automatic void mat_mult(input longint a[], input longint b[], output longint c[],
                                    input int n, input int m, input int p);
      longint acc;
      c = new[n * p];
      for (int i = 0; i < n; i++)
         for (int j = 0; j < p; j++) begin
            acc = 0;
            for (int k = 0; k < m; k++) acc += fx_mul(a[i * m + k], b[k * p + j]);
            c[i * p + j] = clamp_word(acc);
         end
   endfunction

   function automatic void mat_transpose(input longint a[], output longint t[],
                                         input int rows, input int cols);
      t = new[rows * cols];
      for (int i = 0; i < rows; i++)
         for (int j = 0; j < cols; j++) t[j * rows + i] = a[i * cols + j];
   endfunction

   function automatic void load_block(output longint d[], input int base, input int len);
      d = new[len];
      for (int i = 0; i < len; i++) d[i] = filter_store[base + i];
   endfunction

   function automatic estimate_type current_estimate(logic [1:0] st);
      estimate_type e;
      for (int i = 0; i < 3; i++) e.est[i] = filter_store[A_X + i][31:0];
      e.status = st;
      return e;
   endfunction

   // one filter step or store write, returns the expected beat
   function automatic estimate_type predict_item(logic typ, logic [5:0] idx,
                                                 logic signed [31:0] wv,
                                                 logic signed [31:0] z0,
                                                 logic signed [31:0] z1);
      longint f[], h[], q[], r[], x0[], p0[], x[], p[], ft[], fp[], fpft[];
      longint ht[], pht[], s[], si[], k[], hx[], y[], ky[], kt[], rkt[], krkt[];
      longint kh[], ikh[], ikht[], a[], b[], zz[];
      longint det;
      if (typ == REQ_WRITE) begin
         if (idx < STORE_DEPTH) filter_store[idx] = longint'(wv);
         return current_estimate(ST_WRITE);
      end
      load_block(f, A_F, 9); load_block(h, A_H, 6); load_block(q, A_Q, 9);
      load_block(r, A_R, 4); load_block(x0, A_X, 3); load_block(p0, A_P, 9);
      // prediction
      mat_mult(f, x0, x, 3, 3, 1);
      mat_transpose(f, ft, 3, 3);
      mat_mult(f, p0, fp, 3, 3, 3);
      mat_mult(fp, ft, fpft, 3, 3, 3);
      p = new[9];
      foreach (p[i]) p[i] = clamp_word(fpft[i] + q[i]);
      // innovation and its determinant
      mat_transpose(h, ht, 2, 3);
      mat_mult(p, ht, pht, 3, 3, 2);
      mat_mult(h, pht, s, 2, 3, 2);
      foreach (s[i]) s[i] = clamp_word(s[i] + r[i]);
      det = clamp_word(fx_mul(s[0], s[3]) - fx_mul(s[1], s[2]));
      if (det != 0) begin
         si = new[4];
         si[0] = clamp_word((s[3] * ONE) / det);
         si[1] = clamp_word((-s[1] * ONE) / det);
         si[2] = clamp_word((-s[2] * ONE) / det);
         si[3] = clamp_word((s[0] * ONE) / det);
         mat_mult(pht, si, k, 3, 2, 2);
         // state update
         zz = new[2];
         zz[0] = longint'(z0); zz[1] = longint'(z1);
         mat_mult(h, x, hx, 2, 3, 1);
         y = new[2];
         foreach (y[i]) y[i] = clamp_word(zz[i] - hx[i]);
         mat_mult(k, y, ky, 3, 2, 1);
         foreach (x[i]) x[i] = clamp_word(ky[i] + x[i]);
         // joseph covariance update
         mat_transpose(k, kt, 3, 2);
         mat_mult(r, kt, rkt, 2, 2, 3);
         mat_mult(k, rkt, krkt, 3, 2, 3);
         mat_mult(k, h, kh, 3, 2, 3);
         ikh = new[9];
         foreach (ikh[i]) ikh[i] = clamp_word(((i % 4 == 0) ? ONE : 0) - kh[i]);
         mat_transpose(ikh, ikht, 3, 3);
         mat_mult(p, ikht, a, 3, 3, 3);
         mat_mult(ikh, a, b, 3, 3, 3);
         foreach (p[i]) p[i] = clamp_word(b[i] + krkt[i]);
      end
      for (int i = 0; i < 3; i++) filter_store[A_X + i] = x[i];
      for (int i = 0; i < 9; i++) filter_store[A_P + i] = p[i];
      return current_estimate(det == 0 ? ST_SING : ST_DONE);
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   // send one beat, at times with a random gap first; valid stays up for a following beat
   task automatic send_beat(logic typ, logic [5:0] idx, logic signed [31:0] wv,
                            logic signed [31:0] z0, logic signed [31:0] z1);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= typ;
      req_word_index <= idx;
      req_word_value <= wv;
      req_meas_0 <= z0;
      req_meas_1 <= z1;
      do @(posedge clock); while (!req_ready);
      pending_estimates.push_back(predict_item(typ, idx, wv, z0, z1));
   endtask

   task automatic write_word(int idx, longint v);
      send_beat(REQ_WRITE, 6'(idx), 32'(v), $urandom, $urandom);
   endtask

   task automatic measure(logic signed [31:0] z0, logic signed [31:0] z1);
      send_beat(~REQ_WRITE, 6'($urandom), $urandom, z0, z1);
   endtask

   // drop valid and wait for every outstanding estimate
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_estimates.size() != 0) @(posedge clock);
   endtask

   // load a well-behaved constant-acceleration model with small noise
   task automatic load_model(int scale);
      for (int i = 0; i < 9; i++)
         write_word(A_F + i, (i % 4 == 0) ? ONE : ((i == 1 || i == 5) ? ONE / scale : 0));
      for (int i = 0; i < 6; i++) write_word(A_H + i, (i == 0 || i == 4) ? ONE : 0);
      for (int i = 0; i < 9; i++) write_word(A_Q + i, (i % 4 == 0) ? ONE / 64 : 0);
      for (int i = 0; i < 4; i++) write_word(A_R + i, (i % 3 == 0) ? ONE / 4 : 0);
      for (int i = 0; i < 9; i++) write_word(A_P + i, (i % 4 == 0) ? ONE : 0);
   endtask

   // directed: zero store gives a singular step, extremes, out of range words
   task automatic test_directed();
      measure(32'sh7fffffff, 32'sh80000000);
      write_word(63, 32'sh7fffffff);
      write_word(40, -1);
      write_word(A_X, 32'sh7fffffff);
      write_word(A_X + 1, 32'sh80000000);
      write_word(A_X + 2, 32'hffffffff);
      load_model(8);
      measure(32'sh7fffffff, 32'sh80000000);
      measure(0, 0);
      measure(32'sh80000000, 32'sh7fffffff);
      measure(ONE, -ONE);
      drain_results();
   endtask

   // random values: word extremes, zero or any word, otherwise modest magnitudes
   function automatic logic signed [31:0] rand_value();
      case ($urandom_range(0, 9))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $urandom;
         3: return 0;
         default: return $signed($urandom_range(0, 8 * ONE)) - 4 * ONE;
      endcase
   endfunction

   // mostly filter runs on sane models, some with random store words
   task automatic test_random(int beats);
      for (int n = 0; n < beats; n++) begin
         case ($urandom_range(0, 19))
            0: load_model($urandom_range(1, 16));
            1, 2: write_word($urandom_range(0, 63), rand_value());
            3: write_word($urandom_range(0, STORE_DEPTH - 1), $urandom);
            default: measure(rand_value(), rand_value());
         endcase
      end
   endtask

   // hold off until every estimate is back, then continue
   task automatic test_quiet_sender();
      drain_results();
      load_model(4);
      drain_results();
      repeat (4) measure(rand_value(), rand_value());
      drain_results();
   endtask

   task automatic test_no_idle(int beats);
      idle_enable = 1'b0;
      test_random(beats);
   endtask

   // result checker
   always @(posedge clock) begin
      estimate_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_estimates.size() == 0) begin
            report_mismatch("unexpected beat status", rsp_status, -1);
         end else begin
            e = pending_estimates.pop_front();
            if (rsp_est_0 !== e.est[0]) report_mismatch("est_0", rsp_est_0, e.est[0]);
            if (rsp_est_1 !== e.est[1]) report_mismatch("est_1", rsp_est_1, e.est[1]);
            if (rsp_est_2 !== e.est[2]) report_mismatch("est_2", rsp_est_2, e.est[2]);
            if (rsp_status !== e.status) report_mismatch("status", rsp_status, e.status);
         end
      end
   end

   // receiver stall bursts
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (idle_enable && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("** kalman_filter_3state_2meas_core: FAILED **");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < STORE_DEPTH; i++) filter_store[i] = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(300);
      test_quiet_sender();
      test_random(250);
      test_no_idle(100);
      drain_results();
      repeat (50) @(posedge clock);
      if (error_count == 0) $display("** kalman_filter_3state_2meas_core: PASSED **");
      else $display("** kalman_filter_3state_2meas_core: FAILED **");
      $finish;
   end

endmodule
